/* design/snoop_filter_line_controller_macros.svh */
// ----------------------------------------------------------------------------
// Snoop filter line controller assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SNOOP_FILTER_LINE_CONTROLLER_MACROS_SVH
`define SNOOP_FILTER_LINE_CONTROLLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/sflc_pkg.sv */
// ----------------------------------------------------------------------------
// Snoop filter line controller package
// Shared types, codes and default sizes of the snoop filter line controller.
// ----------------------------------------------------------------------------
package sflc_pkg;

   localparam int NUM_HOSTS_DEFAULT = 16;
   localparam int ADDR_BITS_DEFAULT = 46;
   localparam int DATA_BITS_DEFAULT = 64;

   localparam int ADDR_FIELD_BITS = 46;
   localparam int DATA_FIELD_BITS = 64;
   localparam int HOST_FIELD_BITS = 4;

   typedef enum logic [1:0] {
      REQ_READ_EXCL,
      REQ_READ_SHARED,
      REQ_INVALIDATE,
      REQ_UNSUPPORTED
   } req_kind_type;

   typedef enum logic [2:0] {
      LS_INVALID,
      LS_SHARED,
      LS_EXCL,
      LS_NEED_MEM,
      LS_NEED_INV,
      LS_NEED_INV_SH
   } line_state_type;

   typedef enum logic [2:0] {
      KIND_SNOOP_INV,
      KIND_SNOOP_DATA,
      KIND_MEM_READ,
      KIND_CMP_EXCL,
      KIND_CMP_SHARED,
      KIND_DATA,
      KIND_INV_DONE,
      KIND_ERROR
   } result_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE,
      ERR_UNSUPPORTED,
      ERR_BAD_REPLY
   } error_code_type;

   // Input transfer payload, lowest field last.
   typedef struct packed {
      logic [5:0]                 pad;
      logic [DATA_FIELD_BITS-1:0] mem_data;
      logic                       mem_valid;
      logic [HOST_FIELD_BITS-1:0] rsp_host;
      logic                       rsp_shared;
      logic                       rsp_valid;
      logic [ADDR_FIELD_BITS-1:0] req_address;
      logic [HOST_FIELD_BITS-1:0] req_host;
      logic [15:0]                req_tag;
      logic                       req_valid;
   } req_item_type;

   // Result transfer payload, lowest field last.
   typedef struct packed {
      error_code_type             error_code;
      logic [DATA_FIELD_BITS-1:0] data_out;
      logic [15:0]                tag_out;
      logic [ADDR_FIELD_BITS-1:0] line_address;
      logic [HOST_FIELD_BITS-1:0] target_host;
      logic [3:0]                 source_id;
   } rsp_payload_type;

   typedef struct packed {
      result_kind_type kind;
      rsp_payload_type payload;
   } result_type;

   typedef struct packed {
      logic       push;
      logic       finish;
      result_type result;
   } stage_cmd_type;

   typedef struct packed {
      logic ready;
      logic pend_valid;
   } stage_status_type;

endpackage

/* design/snoop_filter_line_controller.sv */
// For a new request the sequencer walks the host state table one entry per
// cycle through its shared index, holding while a snoop waits on the result
// side, sends at most one snoop per entry, and then steps through the reply,
// memory read and answer stages. A result side that holds off tready
// stretches any step that has a result to hand over.
// ----------------------------------------------------------------------------
// Snoop filter line controller
// Back-invalidate snoop filter for one cache line shared by several hosts:
// snoops holders, collects replies, reads memory and answers the requester.
// ----------------------------------------------------------------------------
`include "snoop_filter_line_controller_macros.svh"

module snoop_filter_line_controller #(
   parameter int NUM_HOSTS = sflc_pkg::NUM_HOSTS_DEFAULT,
   parameter int ADDR_BITS = sflc_pkg::ADDR_BITS_DEFAULT,
   parameter int DATA_BITS = sflc_pkg::DATA_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [3:0]   csr_wdata,   // device_id
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_valid, req_tag, req_host, req_address, rsp_valid, rsp_shared,
   // rsp_host, mem_valid, mem_data, zero padding
   input  logic [143:0] req_tdata,
   input  logic [1:0]   req_tuser,   // req_kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // source_id, target_host, line_address, tag_out, data_out, error_code
   output logic [135:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // kind
   output logic         rsp_tlast    // last
);

   localparam int HIDX = $clog2(NUM_HOSTS);

   logic [3:0]                   device_id_ff;
   logic [HIDX-1:0]              tbl_idx;
   logic                         tbl_wr_en;
   sflc_pkg::line_state_type     tbl_wr_state;
   sflc_pkg::line_state_type     tbl_rd_state;
   sflc_pkg::stage_cmd_type      stage_cmd;
   sflc_pkg::stage_status_type   stage_status;
   sflc_pkg::result_type         rsp_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= '0;
      end else if (csr_wen) begin
         device_id_ff <= csr_wdata;
      end
   end

   sflc_state_table #(
      .NUM_HOSTS (NUM_HOSTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .idx      (tbl_idx),
      .wr_en    (tbl_wr_en),
      .wr_state (tbl_wr_state),
      .rd_state (tbl_rd_state)
   );

   sflc_sequencer #(
      .NUM_HOSTS (NUM_HOSTS),
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .device_id    (device_id_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .tbl_idx      (tbl_idx),
      .tbl_wr_en    (tbl_wr_en),
      .tbl_wr_state (tbl_wr_state),
      .tbl_rd_state (tbl_rd_state),
      .stage_cmd    (stage_cmd),
      .stage_status (stage_status)
   );

   sflc_result_stage u_stage (
      .clock      (clock),
      .reset      (reset),
      .cmd        (stage_cmd),
      .status     (stage_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = rsp_result.payload;
   assign rsp_tuser = rsp_result.kind;

   // Every item drains its held result before the next transfer is taken.
   `SFLC_ASSERT_SAME(a_idle_no_held, clock, reset, req_tready,
                     !stage_status.pend_valid, "held result while ready")
   `SFLC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready,
                     !req_tready, "ready right after transfer")
   `SFLC_ASSERT_SAME(a_error_has_code, clock, reset,
                     rsp_tvalid && rsp_result.kind == sflc_pkg::KIND_ERROR,
                     rsp_result.payload.error_code != sflc_pkg::ERR_NONE,
                     "error result without code")

endmodule

/* design/sflc_state_table.sv */
// ----------------------------------------------------------------------------
// Snoop filter line controller host state table
// Per-host line state with one read port and one write port on a shared index.
// ----------------------------------------------------------------------------
module sflc_state_table #(
   parameter int NUM_HOSTS = sflc_pkg::NUM_HOSTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(NUM_HOSTS)-1:0]  idx,
   input  logic                          wr_en,
   input  sflc_pkg::line_state_type      wr_state,
   output sflc_pkg::line_state_type      rd_state
);

   sflc_pkg::line_state_type state_ff [NUM_HOSTS];

   assign rd_state = state_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HOSTS; i++) begin
            state_ff[i] <= sflc_pkg::LS_INVALID;
         end
      end else if (wr_en) begin
         state_ff[idx] <= wr_state;
      end
   end

endmodule

/* design/sflc_result_stage.sv */
// ----------------------------------------------------------------------------
// Snoop filter line controller result stage
// Holds one result back until the next one or the end of the item is known,
// so the final result of an item can carry tlast, then drives the output.
// ----------------------------------------------------------------------------
module sflc_result_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  sflc_pkg::stage_cmd_type  cmd,
   output sflc_pkg::stage_status_type status,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output sflc_pkg::result_type     rsp_result,
   output logic                     rsp_tlast
);

   logic                 pend_valid_ff, pend_valid_in;
   sflc_pkg::result_type pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   sflc_pkg::result_type out_ff, out_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_free;
   logic                 ready;

   assign out_free = !out_valid_ff || rsp_tready;
   assign ready    = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (cmd.push && ready) begin
         // The held result is known not to be the last one.
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = cmd.result;
         pend_valid_in = 1'b1;
      end else if (cmd.finish && pend_valid_ff && out_free) begin
         out_in        = pend_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign status.ready      = ready;
   assign status.pend_valid = pend_valid_ff;
   assign rsp_tvalid        = out_valid_ff;
   assign rsp_result        = out_ff;
   assign rsp_tlast         = out_last_ff;

endmodule

/* design/sflc_sequencer.sv */
// ----------------------------------------------------------------------------
// Snoop filter line controller sequencer
// Walks one input item through request, snoop scan, reply, memory read and
// answer steps, using the host state table one entry per cycle unless a result waits on the result stage.
// ----------------------------------------------------------------------------
module sflc_sequencer #(
   parameter int NUM_HOSTS = sflc_pkg::NUM_HOSTS_DEFAULT,
   parameter int ADDR_BITS = sflc_pkg::ADDR_BITS_DEFAULT,
   parameter int DATA_BITS = sflc_pkg::DATA_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [3:0]                     device_id,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [143:0]                   req_tdata,
   input  logic [1:0]                     req_tuser,
   output logic [$clog2(NUM_HOSTS)-1:0]   tbl_idx,
   output logic                           tbl_wr_en,
   output sflc_pkg::line_state_type       tbl_wr_state,
   input  sflc_pkg::line_state_type       tbl_rd_state,
   output sflc_pkg::stage_cmd_type        stage_cmd,
   input  sflc_pkg::stage_status_type     stage_status
);

   localparam int HIDX = $clog2(NUM_HOSTS);
   localparam int CNT_BITS = $clog2(NUM_HOSTS);
   localparam int AFW = sflc_pkg::ADDR_FIELD_BITS;
   localparam int DFW = sflc_pkg::DATA_FIELD_BITS;
   localparam int HFW = sflc_pkg::HOST_FIELD_BITS;
   localparam int AW = (ADDR_BITS < AFW) ? ADDR_BITS : AFW;
   localparam int DW = (DATA_BITS < DFW) ? DATA_BITS : DFW;
   localparam logic [HIDX-1:0] LAST_IDX = HIDX'(NUM_HOSTS - 1);
   localparam logic [HFW:0] HOST_LIMIT = (HFW + 1)'(NUM_HOSTS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_REQ,
      S_SCAN,
      S_RSP,
      S_CHK,
      S_READ,
      S_DATA,
      S_ANS,
      S_ANS_DATA,
      S_END
   } seq_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_RSP,
      PH_WAIT_DATA
   } phase_type;

   seq_type                seq_ff, seq_in;
   phase_type              phase_ff, phase_in;
   logic [HIDX-1:0]        scan_ff, scan_in;
   logic [CNT_BITS-1:0]    pend_cnt_ff, pend_cnt_in;
   logic                   any_shared_ff, any_shared_in;
   logic                   is_inval_ff, is_inval_in;
   logic                   shared_req_ff, shared_req_in;
   sflc_pkg::req_item_type item_ff, item_in;
   sflc_pkg::req_kind_type kind_ff, kind_in;
   logic [15:0]            held_tag_ff, held_tag_in;
   logic [HIDX-1:0]        held_host_ff, held_host_in;
   logic [AW-1:0]          held_addr_ff, held_addr_in;
   logic [DW-1:0]          held_data_ff, held_data_in;

   logic                   host_ok;
   logic                   rh_ok;
   logic                   reply_inv_ok;
   logic                   reply_sh_ok;

   function automatic sflc_pkg::result_type make_result(
      input sflc_pkg::result_kind_type kind,
      input logic [3:0]                src,
      input logic [HFW-1:0]            host,
      input logic [AFW-1:0]            addr,
      input logic [15:0]               tag,
      input logic [DFW-1:0]            data,
      input sflc_pkg::error_code_type  err
   );
      sflc_pkg::result_type r;
      r.kind                 = kind;
      r.payload.source_id    = src;
      r.payload.target_host  = host;
      r.payload.line_address = addr;
      r.payload.tag_out      = tag;
      r.payload.data_out     = data;
      r.payload.error_code   = err;
      return r;
   endfunction

   assign req_tready = (seq_ff == S_IDLE);

   assign host_ok = ((HFW + 1)'(item_ff.req_host) < HOST_LIMIT);
   assign rh_ok   = ((HFW + 1)'(item_ff.rsp_host) < HOST_LIMIT);
   assign reply_inv_ok = rh_ok && !item_ff.rsp_shared &&
                         (tbl_rd_state == sflc_pkg::LS_NEED_INV ||
                          tbl_rd_state == sflc_pkg::LS_NEED_INV_SH);
   assign reply_sh_ok  = rh_ok && item_ff.rsp_shared &&
                         (tbl_rd_state == sflc_pkg::LS_NEED_INV_SH);

   always_comb begin
      seq_in         = seq_ff;
      phase_in       = phase_ff;
      scan_in        = scan_ff;
      pend_cnt_in    = pend_cnt_ff;
      any_shared_in  = any_shared_ff;
      is_inval_in    = is_inval_ff;
      shared_req_in  = shared_req_ff;
      item_in        = item_ff;
      kind_in        = kind_ff;
      held_tag_in    = held_tag_ff;
      held_host_in   = held_host_ff;
      held_addr_in   = held_addr_ff;
      held_data_in   = held_data_ff;
      tbl_idx        = held_host_ff;
      tbl_wr_en      = 1'b0;
      tbl_wr_state   = sflc_pkg::LS_INVALID;
      stage_cmd      = '0;

      case (seq_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               item_in = sflc_pkg::req_item_type'(req_tdata);
               kind_in = sflc_pkg::req_kind_type'(req_tuser);
               seq_in  = S_REQ;
            end
         end
         S_REQ: begin
            if (phase_ff == PH_IDLE && item_ff.req_valid) begin
               if (kind_ff == sflc_pkg::REQ_UNSUPPORTED || !host_ok) begin
                  stage_cmd.push   = 1'b1;
                  stage_cmd.result = make_result(sflc_pkg::KIND_ERROR, 4'd0,
                     item_ff.req_host, '0, item_ff.req_tag, '0,
                     sflc_pkg::ERR_UNSUPPORTED);
                  if (stage_status.ready) begin
                     seq_in = S_RSP;
                  end
               end else begin
                  phase_in      = PH_WAIT_RSP;
                  held_tag_in   = item_ff.req_tag;
                  held_host_in  = item_ff.req_host[HIDX-1:0];
                  held_addr_in  = item_ff.req_address[AW-1:0];
                  held_data_in  = '0;
                  is_inval_in   = (kind_ff == sflc_pkg::REQ_INVALIDATE);
                  shared_req_in = (kind_ff == sflc_pkg::REQ_READ_SHARED);
                  scan_in       = '0;
                  pend_cnt_in   = '0;
                  any_shared_in = 1'b0;
                  seq_in        = S_SCAN;
               end
            end else begin
               seq_in = S_RSP;
            end
         end
         S_SCAN: begin
            tbl_idx = scan_ff;
            if (scan_ff == held_host_ff) begin
               tbl_wr_en    = 1'b1;
               tbl_wr_state = is_inval_ff ? sflc_pkg::LS_INVALID : sflc_pkg::LS_NEED_MEM;
               scan_in      = scan_ff + HIDX'(1);
               if (scan_ff == LAST_IDX) begin
                  seq_in = S_RSP;
               end
            end else if (tbl_rd_state != sflc_pkg::LS_INVALID) begin
               stage_cmd.push   = 1'b1;
               stage_cmd.result = make_result(
                  shared_req_ff ? sflc_pkg::KIND_SNOOP_DATA : sflc_pkg::KIND_SNOOP_INV,
                  device_id, HFW'(scan_ff), AFW'(held_addr_ff), '0, '0,
                  sflc_pkg::ERR_NONE);
               if (stage_status.ready) begin
                  tbl_wr_en    = 1'b1;
                  tbl_wr_state = shared_req_ff ? sflc_pkg::LS_NEED_INV_SH
                                               : sflc_pkg::LS_NEED_INV;
                  pend_cnt_in  = pend_cnt_ff + CNT_BITS'(1);
                  scan_in      = scan_ff + HIDX'(1);
                  if (scan_ff == LAST_IDX) begin
                     seq_in = S_RSP;
                  end
               end
            end else begin
               scan_in = scan_ff + HIDX'(1);
               if (scan_ff == LAST_IDX) begin
                  seq_in = S_RSP;
               end
            end
         end
         S_RSP: begin
            tbl_idx = item_ff.rsp_host[HIDX-1:0];
            if (phase_ff == PH_WAIT_RSP) begin
               if (item_ff.rsp_valid) begin
                  if (reply_inv_ok || reply_sh_ok) begin
                     tbl_wr_en     = 1'b1;
                     tbl_wr_state  = reply_sh_ok ? sflc_pkg::LS_SHARED
                                                 : sflc_pkg::LS_INVALID;
                     any_shared_in = any_shared_ff || reply_sh_ok;
                     pend_cnt_in   = pend_cnt_ff - CNT_BITS'(1);
                     seq_in        = S_CHK;
                  end else begin
                     stage_cmd.push   = 1'b1;
                     stage_cmd.result = make_result(sflc_pkg::KIND_ERROR, 4'd0,
                        item_ff.rsp_host, '0, '0, '0, sflc_pkg::ERR_BAD_REPLY);
                     if (stage_status.ready) begin
                        seq_in = S_CHK;
                     end
                  end
               end else begin
                  seq_in = S_CHK;
               end
            end else begin
               seq_in = S_DATA;
            end
         end
         S_CHK: begin
            seq_in = (pend_cnt_ff == '0) ? S_READ : S_END;
         end
         S_READ: begin
            if (tbl_rd_state == sflc_pkg::LS_NEED_MEM) begin
               stage_cmd.push   = 1'b1;
               stage_cmd.result = make_result(sflc_pkg::KIND_MEM_READ, 4'd0, '0,
                  AFW'(held_addr_ff), '0, '0, sflc_pkg::ERR_NONE);
               if (stage_status.ready) begin
                  tbl_wr_en    = 1'b1;
                  tbl_wr_state = any_shared_ff ? sflc_pkg::LS_SHARED : sflc_pkg::LS_EXCL;
                  phase_in     = PH_WAIT_DATA;
                  seq_in       = S_DATA;
               end
            end else begin
               phase_in = PH_WAIT_DATA;
               seq_in   = S_DATA;
            end
         end
         S_DATA: begin
            if (phase_ff == PH_WAIT_DATA && is_inval_ff) begin
               seq_in = S_ANS;
            end else if (phase_ff == PH_WAIT_DATA && item_ff.mem_valid) begin
               held_data_in = item_ff.mem_data[DW-1:0];
               seq_in       = S_ANS;
            end else begin
               seq_in = S_END;
            end
         end
         S_ANS: begin
            phase_in = PH_IDLE;
            if (is_inval_ff) begin
               stage_cmd.push   = 1'b1;
               stage_cmd.result = make_result(sflc_pkg::KIND_INV_DONE, 4'd0,
                  HFW'(held_host_ff), '0, held_tag_ff, '0, sflc_pkg::ERR_NONE);
               if (stage_status.ready) begin
                  seq_in = S_END;
               end
            end else if (tbl_rd_state == sflc_pkg::LS_EXCL ||
                         tbl_rd_state == sflc_pkg::LS_SHARED) begin
               stage_cmd.push   = 1'b1;
               stage_cmd.result = make_result(
                  (tbl_rd_state == sflc_pkg::LS_EXCL) ? sflc_pkg::KIND_CMP_EXCL
                                                      : sflc_pkg::KIND_CMP_SHARED,
                  4'd0, HFW'(held_host_ff), '0, held_tag_ff, '0, sflc_pkg::ERR_NONE);
               if (stage_status.ready) begin
                  seq_in = S_ANS_DATA;
               end
            end else begin
               seq_in = S_ANS_DATA;
            end
         end
         S_ANS_DATA: begin
            stage_cmd.push   = 1'b1;
            stage_cmd.result = make_result(sflc_pkg::KIND_DATA, 4'd0,
               HFW'(held_host_ff), '0, held_tag_ff, DFW'(held_data_ff),
               sflc_pkg::ERR_NONE);
            if (stage_status.ready) begin
               seq_in = S_END;
            end
         end
         S_END: begin
            // Release the held result with tlast set.
            stage_cmd.finish = 1'b1;
            if (stage_status.ready) begin
               seq_in = S_IDLE;
            end
         end
         default: begin
            seq_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= S_IDLE;
         phase_ff      <= PH_IDLE;
         scan_ff       <= '0;
         pend_cnt_ff   <= '0;
         any_shared_ff <= 1'b0;
         is_inval_ff   <= 1'b0;
         shared_req_ff <= 1'b0;
         held_tag_ff   <= '0;
         held_host_ff  <= '0;
         held_addr_ff  <= '0;
         held_data_ff  <= '0;
      end else begin
         seq_ff        <= seq_in;
         phase_ff      <= phase_in;
         scan_ff       <= scan_in;
         pend_cnt_ff   <= pend_cnt_in;
         any_shared_ff <= any_shared_in;
         is_inval_ff   <= is_inval_in;
         shared_req_ff <= shared_req_in;
         held_tag_ff   <= held_tag_in;
         held_host_ff  <= held_host_in;
         held_addr_ff  <= held_addr_in;
         held_data_ff  <= held_data_in;
      end
      item_ff <= item_in;
      kind_ff <= kind_in;
   end

endmodule

/* tb/snoop_filter_line_controller_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Snoop filter line controller testbench
// Drives request, snoop reply and memory data transfers into the controller,
// predicts every snoop, memory read, completion and error it should return,
// and checks each result transfer field by field against that prediction.
// ----------------------------------------------------------------------------
module snoop_filter_line_controller_test;

   localparam int HOSTS = sflc_pkg::NUM_HOSTS_DEFAULT;

   typedef enum {
      SEQ_IDLE,
      SEQ_WAIT_REPLY,
      SEQ_ISSUE_READ,
      SEQ_WAIT_DATA,
      SEQ_ANSWER
   } seq_phase_type;

   typedef struct packed {
      sflc_pkg::result_type res;
      logic                 last;
   } line_result_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         csr_wen = 1'b0;
   logic [3:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [143:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;

   // Line state as the controller should hold it.
   seq_phase_type            seq_phase = SEQ_IDLE;
   sflc_pkg::line_state_type host_state [HOSTS];
   logic [3:0]               device_id = '0;
   logic                     skip_read = 1'b0;
   logic                     skip_reply = 1'b0;
   logic                     is_invalidate = 1'b0;
   logic [15:0]              held_tag = '0;
   logic [3:0]               held_host = '0;
   logic [45:0]              held_address = '0;
   logic [63:0]              held_data = '0;

   line_result_type pending_results [$];
   int failures = 0;
   int handled_items = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   snoop_filter_line_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic sflc_pkg::result_type make_result(
      sflc_pkg::result_kind_type kind, logic [3:0] src, logic [3:0] host,
      logic [45:0] addr, logic [15:0] tag, logic [63:0] data,
      sflc_pkg::error_code_type err);
      sflc_pkg::result_type r;
      r.kind                 = kind;
      r.payload.source_id    = src;
      r.payload.target_host  = host;
      r.payload.line_address = addr;
      r.payload.tag_out      = tag;
      r.payload.data_out     = data;
      r.payload.error_code   = err;
      return r;
   endfunction

   function automatic bit replies_outstanding();
      for (int h = 0; h < HOSTS; h++) begin
         if (host_state[h] == sflc_pkg::LS_NEED_INV ||
             host_state[h] == sflc_pkg::LS_NEED_INV_SH) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Walks one accepted transfer through every phase it can reach and queues
   // the results it should cause, in order.
   task automatic absorb_item(input sflc_pkg::req_item_type it,
                              input sflc_pkg::req_kind_type k);
      sflc_pkg::result_type     batch [$];
      line_result_type          entry;
      sflc_pkg::line_state_type st;
      sflc_pkg::line_state_type grant;
      bit                       took;
      bit                       ok;
      took = 1'b0;
      if (seq_phase == SEQ_IDLE && it.req_valid) begin
         took = 1'b1;
         if (k == sflc_pkg::REQ_UNSUPPORTED) begin
            batch = {batch, make_result(sflc_pkg::KIND_ERROR, '0, it.req_host, '0,
                                        it.req_tag, '0, sflc_pkg::ERR_UNSUPPORTED)};
         end else begin
            seq_phase     = SEQ_WAIT_REPLY;
            held_tag      = it.req_tag;
            held_host     = it.req_host;
            held_address  = it.req_address;
            held_data     = '0;
            skip_read     = (k == sflc_pkg::REQ_INVALIDATE);
            skip_reply    = (k == sflc_pkg::REQ_INVALIDATE);
            is_invalidate = (k == sflc_pkg::REQ_INVALIDATE);
            for (int h = 0; h < HOSTS; h++) begin
               if (h == it.req_host) begin
                  host_state[h] = (k == sflc_pkg::REQ_INVALIDATE) ? sflc_pkg::LS_INVALID
                                                                  : sflc_pkg::LS_NEED_MEM;
               end else if (host_state[h] != sflc_pkg::LS_INVALID) begin
                  host_state[h] = (k == sflc_pkg::REQ_READ_SHARED)
                                  ? sflc_pkg::LS_NEED_INV_SH : sflc_pkg::LS_NEED_INV;
                  batch = {batch, make_result((k == sflc_pkg::REQ_READ_SHARED)
                                              ? sflc_pkg::KIND_SNOOP_DATA
                                              : sflc_pkg::KIND_SNOOP_INV,
                                              device_id, h[3:0], held_address, '0, '0,
                                              sflc_pkg::ERR_NONE)};
               end
            end
         end
      end
      if (seq_phase == SEQ_WAIT_REPLY) begin
         if (it.rsp_valid) begin
            took = 1'b1;
            ok = 1'b0;
            st = host_state[it.rsp_host];
            if (!it.rsp_shared && (st == sflc_pkg::LS_NEED_INV ||
                                   st == sflc_pkg::LS_NEED_INV_SH)) begin
               host_state[it.rsp_host] = sflc_pkg::LS_INVALID;
               ok = 1'b1;
            end else if (it.rsp_shared && st == sflc_pkg::LS_NEED_INV_SH) begin
               host_state[it.rsp_host] = sflc_pkg::LS_SHARED;
               ok = 1'b1;
            end
            if (!ok) begin
               batch = {batch, make_result(sflc_pkg::KIND_ERROR, '0, it.rsp_host, '0,
                                           '0, '0, sflc_pkg::ERR_BAD_REPLY)};
            end
         end
         if (!replies_outstanding()) begin
            seq_phase = SEQ_ISSUE_READ;
         end
      end
      if (seq_phase == SEQ_ISSUE_READ) begin
         seq_phase = SEQ_WAIT_DATA;
         if (host_state[held_host] == sflc_pkg::LS_NEED_MEM) begin
            batch = {batch, make_result(sflc_pkg::KIND_MEM_READ, '0, '0, held_address,
                                        '0, '0, sflc_pkg::ERR_NONE)};
            // The requester only gets exclusive ownership if no one kept a copy.
            grant = sflc_pkg::LS_EXCL;
            for (int h = 0; h < HOSTS; h++) begin
               if (host_state[h] == sflc_pkg::LS_SHARED) begin
                  grant = sflc_pkg::LS_SHARED;
               end
            end
            host_state[held_host] = grant;
         end
      end
      if (seq_phase == SEQ_WAIT_DATA) begin
         if (skip_read) begin
            seq_phase = SEQ_ANSWER;
         end else if (it.mem_valid) begin
            took = 1'b1;
            held_data = it.mem_data;
            seq_phase = SEQ_ANSWER;
         end
      end
      if (seq_phase == SEQ_ANSWER) begin
         seq_phase = SEQ_IDLE;
         if (!skip_reply) begin
            st = host_state[held_host];
            if (st == sflc_pkg::LS_EXCL) begin
               batch = {batch, make_result(sflc_pkg::KIND_CMP_EXCL, '0, held_host, '0,
                                           held_tag, '0, sflc_pkg::ERR_NONE)};
            end else if (st == sflc_pkg::LS_SHARED) begin
               batch = {batch, make_result(sflc_pkg::KIND_CMP_SHARED, '0, held_host, '0,
                                           held_tag, '0, sflc_pkg::ERR_NONE)};
            end
            batch = {batch, make_result(sflc_pkg::KIND_DATA, '0, held_host, '0,
                                        held_tag, held_data, sflc_pkg::ERR_NONE)};
         end
         if (is_invalidate) begin
            batch = {batch, make_result(sflc_pkg::KIND_INV_DONE, '0, held_host, '0,
                                        held_tag, '0, sflc_pkg::ERR_NONE)};
         end
      end
      for (int i = 0; i < batch.size(); i++) begin
         entry.res  = batch[i];
         entry.last = (i == batch.size() - 1);
         pending_results = {pending_results, entry};
      end
      if (took) begin
         handled_items++;
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   // Prediction and checking share one process so that a transfer in and a
   // result out on the same edge are always seen in that order.
   always @(posedge clock) begin
      line_result_type           want;
      sflc_pkg::rsp_payload_type got;
      if (reset) begin
         seq_phase = SEQ_IDLE;
         for (int h = 0; h < HOSTS; h++) begin
            host_state[h] = sflc_pkg::LS_INVALID;
         end
         device_id     = '0;
         skip_read     = 1'b0;
         skip_reply    = 1'b0;
         is_invalidate = 1'b0;
         held_tag      = '0;
         held_host     = '0;
         held_address  = '0;
         held_data     = '0;
      end else begin
         if (csr_wen) begin
            device_id = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            absorb_item(sflc_pkg::req_item_type'(req_tdata),
                        sflc_pkg::req_kind_type'(req_tuser));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = sflc_pkg::rsp_payload_type'(rsp_tdata);
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer: kind %0d target %0d", rsp_tuser,
                      got.target_host);
               failures++;
            end else begin
               want = pending_results.pop_front();
               compare_field("kind", want.res.kind, rsp_tuser);
               compare_field("source_id", want.res.payload.source_id, got.source_id);
               compare_field("target_host", want.res.payload.target_host, got.target_host);
               compare_field("line_address", want.res.payload.line_address,
                             got.line_address);
               compare_field("tag_out", want.res.payload.tag_out, got.tag_out);
               compare_field("data_out", want.res.payload.data_out, got.data_out);
               compare_field("error_code", want.res.payload.error_code, got.error_code);
               compare_field("last", want.last, rsp_tlast);
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(input sflc_pkg::req_item_type it,
                            input sflc_pkg::req_kind_type k);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= it;
      req_tuser  <= k;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic sflc_pkg::req_item_type build_item(
      logic rv, logic [15:0] tag, logic [3:0] host, logic [45:0] addr, logic pv,
      logic psh, logic [3:0] ph, logic mv, logic [63:0] md);
      sflc_pkg::req_item_type it;
      it             = '0;
      it.req_valid   = rv;
      it.req_tag     = tag;
      it.req_host    = host;
      it.req_address = addr;
      it.rsp_valid   = pv;
      it.rsp_shared  = psh;
      it.rsp_host    = ph;
      it.mem_valid   = mv;
      it.mem_data    = md;
      return it;
   endfunction

   task automatic write_device_id(input logic [3:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   // Waits for every outstanding result, then lets the sequencer settle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      @(negedge clock);
   endtask

   // Builds the next transfer from the predicted sequencer state: mostly the
   // reply or data the controller is waiting for, with some noise mixed in.
   task automatic roll_item(output sflc_pkg::req_item_type it,
                            output sflc_pkg::req_kind_type k);
      int pick;
      int sel;
      int waiting [$];
      logic [3:0] h;
      it             = '0;
      it.req_tag     = 16'($urandom);
      it.req_host    = 4'($urandom);
      it.req_address = 46'({$urandom, $urandom});
      it.rsp_shared  = 1'($urandom);
      it.rsp_host    = 4'($urandom);
      it.mem_data    = {$urandom, $urandom};
      it.req_valid   = ($urandom_range(99) < 20);
      it.rsp_valid   = ($urandom_range(99) < 15);
      it.mem_valid   = ($urandom_range(99) < 20);
      sel = $urandom_range(9);
      if (sel < 3) begin
         k = sflc_pkg::REQ_READ_EXCL;
      end else if (sel < 7) begin
         k = sflc_pkg::REQ_READ_SHARED;
      end else if (sel < 9) begin
         k = sflc_pkg::REQ_INVALIDATE;
      end else begin
         k = sflc_pkg::REQ_UNSUPPORTED;
      end
      pick = $urandom_range(99);
      case (seq_phase)
         SEQ_IDLE: begin
            it.req_valid = (pick < 90);
         end
         SEQ_WAIT_REPLY: begin
            if (pick < 85) begin
               for (int i = 0; i < HOSTS; i++) begin
                  if (host_state[i] == sflc_pkg::LS_NEED_INV ||
                      host_state[i] == sflc_pkg::LS_NEED_INV_SH) begin
                     waiting = {waiting, i};
                  end
               end
               h = 4'(waiting[$urandom_range(waiting.size() - 1)]);
               it.rsp_valid  = 1'b1;
               it.rsp_host   = h;
               it.rsp_shared = (host_state[h] == sflc_pkg::LS_NEED_INV_SH) ? 1'($urandom)
                                                                          : 1'b0;
            end
         end
         default: begin
            it.mem_valid = (pick < 85);
         end
      endcase
   endtask

   task automatic random_traffic(input int items);
      sflc_pkg::req_item_type it;
      sflc_pkg::req_kind_type k;
      int goal;
      goal = handled_items + items;
      // Keep going past the goal until the open transaction has completed.
      while (handled_items < goal || seq_phase != SEQ_IDLE) begin
         roll_item(it, k);
         send_item(it, k);
      end
   endtask

   task automatic test_corner_cases();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // Unsupported request with all-ones tag, host and address.
      send_item(build_item(1'b1, 16'hFFFF, 4'hF, '1, 1'b0, 1'b0, 4'h0, 1'b0, '0),
                sflc_pkg::REQ_UNSUPPORTED);
      // Reply and memory data while idle are ignored.
      send_item(build_item(1'b0, '0, '0, '0, 1'b1, 1'b1, 4'hF, 1'b1, '1),
                sflc_pkg::REQ_READ_EXCL);
      // Exclusive read with no holders, memory data on the same transfer.
      send_item(build_item(1'b1, 16'h0000, 4'h0, '1, 1'b0, 1'b0, 4'h0, 1'b1, '1),
                sflc_pkg::REQ_READ_EXCL);
      // Shared read snoops host 0 for data.
      send_item(build_item(1'b1, 16'h1234, 4'hF, '0, 1'b0, 1'b0, 4'h0, 1'b0, '0),
                sflc_pkg::REQ_READ_SHARED);
      // A request while busy is ignored; a reply from a host not snooped is an error.
      send_item(build_item(1'b1, 16'hBEEF, 4'h2, '1, 1'b1, 1'b0, 4'h5, 1'b0, '0),
                sflc_pkg::REQ_READ_EXCL);
      send_item(build_item(1'b0, '0, '0, '0, 1'b1, 1'b1, 4'h0, 1'b0, '0),
                sflc_pkg::REQ_READ_EXCL);
      // Reply while waiting for memory data is ignored.
      send_item(build_item(1'b0, '0, '0, '0, 1'b1, 1'b0, 4'h0, 1'b0, '0),
                sflc_pkg::REQ_READ_EXCL);
      send_item(build_item(1'b0, '0, '0, '0, 1'b0, 1'b0, 4'h0, 1'b1, '0),
                sflc_pkg::REQ_READ_EXCL);
      // Exclusive read invalidates both sharers; a shared reply is not allowed.
      send_item(build_item(1'b1, 16'h8001, 4'h7, 46'h2AAA_AAAA_AAAA, 1'b0, 1'b0, 4'h0,
                           1'b0, '0), sflc_pkg::REQ_READ_EXCL);
      send_item(build_item(1'b0, '0, '0, '0, 1'b1, 1'b1, 4'h0, 1'b0, '0),
                sflc_pkg::REQ_READ_EXCL);
      send_item(build_item(1'b0, '0, '0, '0, 1'b1, 1'b0, 4'h0, 1'b0, '0),
                sflc_pkg::REQ_READ_EXCL);
      send_item(build_item(1'b0, '0, '0, '0, 1'b1, 1'b0, 4'hF, 1'b1,
                           64'h5555_5555_5555_5555), sflc_pkg::REQ_READ_EXCL);
      // Invalidate snoops the owner, then finishes without a memory read.
      send_item(build_item(1'b1, 16'h7FFE, 4'h3, 46'h1555_5555_5555, 1'b0, 1'b0, 4'h0,
                           1'b0, '0), sflc_pkg::REQ_INVALIDATE);
      send_item(build_item(1'b0, '0, '0, '0, 1'b1, 1'b0, 4'h7, 1'b0, '0),
                sflc_pkg::REQ_READ_EXCL);
      // Invalidate with no holders completes on its own transfer.
      send_item(build_item(1'b1, 16'h00FF, 4'h9, '0, 1'b0, 1'b0, 4'h0, 1'b0, '0),
                sflc_pkg::REQ_INVALIDATE);
      // Shared read with no other holder is granted exclusive.
      send_item(build_item(1'b1, 16'hA5A5, 4'h4, 46'h3, 1'b0, 1'b0, 4'h0, 1'b1,
                           64'h8000_0000_0000_0001), sflc_pkg::REQ_READ_SHARED);
   endtask

   task automatic test_slow_receiver();
      sender_idle_pct    = 35;
      receiver_stall_pct = 59;
      random_traffic(130);
   endtask

   task automatic test_slow_sender();
      sender_idle_pct    = 59;
      receiver_stall_pct = 35;
      random_traffic(130);
   endtask

   task automatic test_full_rate();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      random_traffic(130);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_device_id(4'hF);
      test_corner_cases();
      settle();
      write_device_id(4'h0);
      test_slow_receiver();
      settle();
      write_device_id(4'($urandom_range(1, 14)));
      test_slow_sender();
      settle();
      write_device_id(4'($urandom));
      test_full_rate();
      settle();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
